>>> hw/rtl/bsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared widths, register map and reset values for the bisection square root.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int DATA_W   = 32;
  localparam int STEP_W   = 7;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int TDATA_W  = 40;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;
  localparam int MAX_ITER_DEF  = 64;

  localparam logic [DATA_W-1:0] EPSILON_RST = 32'd6554;

  typedef enum logic [0:0] {
    REG_EPSILON = 1'b0
  } reg_idx_t;

endpackage : bsr_pkg
`default_nettype wire

>>> hw/rtl/bisection_square_root.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bisection_square_root
// Unsigned fixed-point square root by bisection with one shared multiplier.
// ----------------------------------------------------------------------------
// Each bisection step does a midpoint add, a 32x32 square and a compare with
// the tolerance window in turn, for up to MAX_ITER steps per item; radicands
// zero and one skip the search. The single squaring multiplier is reused by
// every step. The input is not ready while an item is searched; a finished
// item waits in the output register while the next item may already be
// accepted.
module bisection_square_root #(
  parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = bsr_pkg::INT_BITS_DEF,
  parameter int MAX_ITER  = bsr_pkg::MAX_ITER_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [bsr_pkg::DATA_W-1:0]   in_tdata,   // radicand[31:0]
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [bsr_pkg::TDATA_W-1:0]       out_tdata,  // root[31:0], converged[32],
                                                        // steps_taken[39:33]
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bsr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [bsr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [bsr_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import bsr_pkg::*;

  localparam int VAL_W = (INT_BITS + FRAC_BITS >= DATA_W) ? DATA_W : INT_BITS + FRAC_BITS;
  localparam logic [PROD_W-1:0] VAL_MASK64 = (VAL_W >= DATA_W) ? {PROD_W{1'b1}}
                                             : ((PROD_W'(1) << VAL_W) - PROD_W'(1));
  localparam logic [DATA_W-1:0] VAL_MASK = VAL_MASK64[DATA_W-1:0];
  localparam logic [DATA_W-1:0] ONE      = DATA_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] ITER_CAP = STEP_W'(MAX_ITER);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [DATA_W-1:0]   eps_r;
  logic [DATA_W-1:0]   low_r;
  logic [DATA_W-1:0]   high_r;
  logic [DATA_W-1:0]   mid_r;
  logic [PROD_W-1:0]   sq_r;
  logic [PROD_W:0]     lim_hi_r;
  logic [PROD_W-1:0]   lim_lo_r;
  logic [PROD_W-1:0]   target_r;
  logic [STEP_W-1:0]   step_r;
  logic                conv_r;
  logic                out_valid_r;
  logic [TDATA_W-1:0]  out_data_r;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                in_fire;
  logic [DATA_W-1:0]   v_in;
  logic [PROD_W-1:0]   target_in;
  logic [PROD_W-1:0]   tol_in;
  logic [DATA_W:0]     mid_sum;
  logic                sq_lt;
  logic                in_window;
  logic [STEP_W-1:0]   step_inc;
  logic                out_free;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_AW-1] == 1'b0);

  always_comb begin
    unique case (cfg_idx)
      REG_EPSILON: cfg_prdata = eps_r;
      default:     cfg_prdata = '0;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign v_in      = in_tdata & VAL_MASK;
  assign target_in = {{DATA_W{1'b0}}, v_in} << FRAC_BITS;
  assign tol_in    = {{DATA_W{1'b0}}, eps_r} << FRAC_BITS;

  assign mid_sum   = {1'b0, low_r} + {1'b0, high_r};
  assign sq_lt     = (sq_r < target_r);
  assign in_window = ({1'b0, sq_r} <= lim_hi_r) && (sq_r >= lim_lo_r);
  assign step_inc  = step_r + STEP_W'(1);
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eps_r       <= EPSILON_RST;
      low_r       <= '0;
      high_r      <= '0;
      mid_r       <= '0;
      step_r      <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        eps_r <= cfg_pwdata;
      end
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            step_r   <= '0;
            low_r    <= '0;
            high_r   <= (v_in < ONE) ? ONE : v_in;
            target_r <= target_in;
            lim_hi_r <= {1'b0, target_in} + {1'b0, tol_in};
            lim_lo_r <= (target_in >= tol_in) ? (target_in - tol_in) : '0;
            if (v_in == '0 || v_in == ONE) begin
              mid_r   <= v_in;
              conv_r  <= 1'b1;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_MID;
            end
          end
        end
        ST_MID: begin
          mid_r   <= mid_sum[DATA_W:1];
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          sq_r    <= {{DATA_W{1'b0}}, mid_r} * {{DATA_W{1'b0}}, mid_r};
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          step_r <= step_inc;
          if (sq_lt) begin
            low_r <= mid_r;
          end else begin
            high_r <= mid_r;
          end
          conv_r <= in_window;
          if (in_window || step_inc == ITER_CAP) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_MID;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {step_r, conv_r, mid_r};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_cap_when_not_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[DATA_W]) |-> (out_tdata[TDATA_W-1:DATA_W+1] == ITER_CAP))
    else $error("result without convergence before the step cap");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MID) |-> (low_r <= high_r))
    else $error("bisection bounds crossed");

  a_cmp_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |=> (state_r == ST_MID || state_r == ST_FIN))
    else $error("compare step left the search loop unexpectedly");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (step_r <= ITER_CAP))
    else $error("step count beyond cap");

endmodule : bisection_square_root
`default_nettype wire
